// ===== hdl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int ADDR_W = 14;
  localparam int END_W  = 15;
  localparam int DATA_W = 16;
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 1;

  localparam logic [FUNC_W-1:0] FUNC_PRINT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DOWN  = 2'd2;

  localparam logic [IDX_W-1:0] REG_REGION_START = 1'd0;
  localparam logic [IDX_W-1:0] REG_REGION_END   = 1'd1;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_WHITE   = 8'h0f;

  localparam logic [END_W-1:0] MEM_WORDS = 15'd16384;
  localparam logic [END_W-1:0] ADDR_MAX  = 15'h3fff;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_STEP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

// ===== hdl/tcce_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tcce_cmd_if
// Command channel: one character or scroll request per transfer.
// ----------------------------------------------------------------------------
interface tcce_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [tcce_pkg::FUNC_W-1:0] func;
  logic [tcce_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, func, char_code, input ready);
  modport sink   (input valid, func, char_code, output ready);
endinterface

// ===== hdl/tcce_res_if.sv =====
// ----------------------------------------------------------------------------
// tcce_res_if
// Result channel: cell write and updated cursor / view addresses.
// ----------------------------------------------------------------------------
interface tcce_res_if;
  logic                       valid;
  logic                       ready;
  logic                       mem_write;
  logic [tcce_pkg::ADDR_W-1:0] mem_addr;
  logic [tcce_pkg::DATA_W-1:0] mem_data;
  logic [tcce_pkg::ADDR_W-1:0] cursor_address;
  logic [tcce_pkg::ADDR_W-1:0] view_address;

  modport source (output valid, mem_write, mem_addr, mem_data, cursor_address,
                  view_address, input ready);
  modport sink   (input valid, mem_write, mem_addr, mem_data, cursor_address,
                  view_address, output ready);
endinterface

// ===== hdl/tcce_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tcce_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface tcce_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tcce_pkg::IDX_W-1:0] index;
  logic [tcce_pkg::END_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/text_console_cursor_engine_core.sv =====
// Scroll up or unused code: the command passes S_EXEC, then S_EMIT registers the result.
// Print and scroll down: S_EXEC, then S_STEP, then S_EMIT. Print stays in S_STEP for n
//   catch-up line scrolls (one per cycle on the view adders); scroll down takes at most one
//   line scroll. S_EMIT waits while an earlier result is stalled; commands are taken in S_IDLE.
// Reset (rst, synchronous): region 0..16384, cursor and view at 0, no result pending.
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// Cursor and view start tracking for one text console region, with
// iterative catch-up scrolling.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core #(
  parameter int LINE_WIDTH   = 80,
  parameter int SCREEN_CELLS = 2000
) (
  input  logic        clk,
  input  logic        rst,
  tcce_cfg_if.sink    cfg,
  tcce_cmd_if.sink    cmd,
  tcce_res_if.source  res
);
  import tcce_pkg::*;

  localparam int COL_W = $clog2(LINE_WIDTH);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(LINE_WIDTH - 1);
  localparam logic [END_W-1:0]  LW_E     = END_W'(LINE_WIDTH);
  localparam logic [END_W-1:0]  SC_E     = END_W'(SCREEN_CELLS);
  localparam logic [ADDR_W-1:0] LW_A     = ADDR_W'(LINE_WIDTH);

  state_t state;

  logic [ADDR_W-1:0] region_start;
  logic [END_W-1:0]  region_end;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] view;
  logic [COL_W-1:0]  col;
  logic [FUNC_W-1:0] func_q;
  logic [CHAR_W-1:0] char_q;
  logic              catchup;
  logic              wr;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;
  logic              wr_next;
  logic [ADDR_W-1:0] addr_next;
  logic [DATA_W-1:0] data_next;

  logic [END_W-1:0] end_eff;
  logic [END_W-1:0] curs_inc;
  logic [END_W-1:0] curs_nl;
  logic [END_W-1:0] curs_nl_chk;
  logic [END_W-1:0] view_sc;
  logic [END_W-1:0] view_lw;
  logic [END_W-1:0] rs_lw;
  logic             below;
  logic             can_down;

  assign end_eff     = (region_end > MEM_WORDS) ? MEM_WORDS : region_end;
  assign curs_inc    = {1'b0, cursor} + 15'd1;
  assign curs_nl_chk = {1'b0, cursor} + LW_E;
  assign curs_nl     = curs_nl_chk - END_W'(col);

  // view adders and compares, used by the scroll up, catch-up and scroll-down steps
  assign view_sc  = {1'b0, view} + SC_E;
  assign view_lw  = {1'b0, view} + LW_E;
  assign rs_lw    = {1'b0, region_start} + LW_E;
  assign below    = {1'b0, cursor} >= view_sc;
  assign can_down = (view_sc < end_eff) && (view_lw <= ADDR_MAX);

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    wr_next   = 1'b0;
    addr_next = '0;
    data_next = '0;
    if (func_q == FUNC_PRINT) begin
      if (char_q == CH_BACKSPACE) begin
        if (cursor > region_start) begin
          wr_next   = 1'b1;
          addr_next = cursor - 14'd1;
          data_next = {ATTR_WHITE, CH_BLANK};
        end
      end else if (char_q != CH_NEWLINE) begin
        if (curs_inc < end_eff) begin
          wr_next   = 1'b1;
          addr_next = cursor;
          data_next = {ATTR_WHITE, char_q};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      region_start <= '0;
      region_end   <= MEM_WORDS;
      cursor       <= '0;
      view         <= '0;
      col          <= '0;
      res.valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_REGION_START: begin
            region_start <= cfg.data[ADDR_W-1:0];
            cursor       <= cfg.data[ADDR_W-1:0];
            view         <= cfg.data[ADDR_W-1:0];
            col          <= '0;
          end
          REG_REGION_END: region_end <= cfg.data;
          default: ;
        endcase
      end

      if (res.valid && res.ready && (state != S_EMIT)) begin
        res.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            func_q <= cmd.func;
            char_q <= cmd.char_code;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          wr      <= wr_next;
          addr    <= addr_next;
          data    <= data_next;
          catchup <= (func_q == FUNC_PRINT);
          state   <= ((func_q == FUNC_PRINT) || (func_q == FUNC_DOWN)) ? S_STEP : S_EMIT;
          case (func_q)
            FUNC_PRINT: begin
              if (char_q == CH_NEWLINE) begin
                if (curs_nl_chk < end_eff) begin
                  cursor <= curs_nl[ADDR_W-1:0];
                  col    <= '0;
                end
              end else if (char_q == CH_BACKSPACE) begin
                if (cursor > region_start) begin
                  cursor <= cursor - 14'd1;
                  col    <= (col == '0) ? COL_LAST : col - COL_W'(1);
                end
              end else begin
                if (curs_inc < end_eff) begin
                  cursor <= curs_inc[ADDR_W-1:0];
                  col    <= (col == COL_LAST) ? '0 : col + COL_W'(1);
                end
              end
            end
            FUNC_UP: begin
              if (view > region_start) begin
                if ({1'b0, view} >= rs_lw) begin
                  view <= view - LW_A;
                end else begin
                  view <= region_start;
                end
              end
            end
            default: ;
          endcase
        end
        S_STEP: begin
          if (catchup) begin
            if (below && can_down) begin
              view <= view_lw[ADDR_W-1:0];
            end else begin
              state <= S_EMIT;
            end
          end else begin
            if (can_down) begin
              view <= view_lw[ADDR_W-1:0];
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res.valid || res.ready) begin
            res.valid          <= 1'b1;
            res.mem_write      <= wr;
            res.mem_addr       <= addr;
            res.mem_data       <= data;
            res.cursor_address <= cursor;
            res.view_address   <= view;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/tcce_checker.sv =====
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks for the text console cursor engine, bound to the core.
// ----------------------------------------------------------------------------
module tcce_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        mem_write,
  input logic [13:0] mem_addr,
  input logic [15:0] mem_data,
  input logic [13:0] cursor_address,
  input logic [13:0] view_address
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted while previous one in progress");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !mem_write) |-> (mem_addr == 14'd0 && mem_data == 16'd0))
    else $error("cell fields nonzero without a write");

  a_white_attr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mem_write) |-> (mem_data[15:8] == 8'h0f))
    else $error("written cell lacks white attribute");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cursor_address)
      && $stable(view_address) && $stable(mem_data)))
    else $error("stalled result changed");

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (cmd.valid),
  .in_ready       (cmd.ready),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .mem_write      (res.mem_write),
  .mem_addr       (res.mem_addr),
  .mem_data       (res.mem_data),
  .cursor_address (res.cursor_address),
  .view_address   (res.view_address)
);

// ===== verif/tb_text_console_cursor_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine_core
// Self-checking bench for the text console engine. Each command transfer
// updates a cursor/view model in a scoreboard, and every result transfer is
// compared against the oldest prediction field by field. The run has a
// short directed part, then random phases under different region settings,
// with random stalls on both channels and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine_core;
  import tcce_pkg::*;

  localparam int LINE_W     = 80;
  localparam int SCREEN_N   = 2000;
  localparam int TOP_WORDS  = 16384;
  localparam int LAST_ADDR  = 16383;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASES     = 10;
  localparam int PHASE_ITEMS = 163;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] view;
  } console_res_t;

  class console_scoreboard;
    console_res_t expected_q[$];
    int unsigned  errors;
    int           rstart, rend, cur, view;

    function new();
      errors = 0;
      rstart = 0;
      rend   = TOP_WORDS;
      cur    = 0;
      view   = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [END_W-1:0] d);
      if (idx == REG_REGION_START) begin
        rstart = int'(d) & LAST_ADDR;
        cur    = rstart;
        view   = rstart;
      end else begin
        rend = int'(d);
      end
    endfunction

    function bit view_down();
      int top;
      top = (rend > TOP_WORDS) ? TOP_WORDS : rend;
      if (view + SCREEN_N < top && view + LINE_W <= LAST_ADDR) begin
        view += LINE_W;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_cmd(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
      console_res_t r;
      int top, off, nc;
      bit moved;
      top = (rend > TOP_WORDS) ? TOP_WORDS : rend;
      r = '0;
      case (f)
        FUNC_PRINT: begin
          if (c == CH_NEWLINE) begin
            if (cur + LINE_W < top) begin
              off = (cur >= rstart) ? cur - rstart : 0;
              nc  = rstart + LINE_W * (off / LINE_W + 1);
              if (nc <= LAST_ADDR) cur = nc;
            end
          end else if (c == CH_BACKSPACE) begin
            if (cur > rstart) begin
              cur    = cur - 1;
              r.wr   = 1'b1;
              r.addr = cur[ADDR_W-1:0];
              r.data = {ATTR_WHITE, CH_BLANK};
            end
          end else if (cur + 1 < top) begin
            r.wr   = 1'b1;
            r.addr = cur[ADDR_W-1:0];
            r.data = {ATTR_WHITE, c};
            cur    = cur + 1;
          end
          while (cur >= view + SCREEN_N) begin
            moved = view_down();
            if (!moved) break;
          end
        end
        FUNC_UP: begin
          if (view > rstart) view = (view >= rstart + LINE_W) ? view - LINE_W : rstart;
        end
        FUNC_DOWN: moved = view_down();
        default: ;
      endcase
      r.cur  = cur[ADDR_W-1:0];
      r.view = view[ADDR_W-1:0];
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check(console_res_t got);
      console_res_t exp;
      if (expected_q.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      exp = expected_q.pop_front();
      if (got.wr !== exp.wr)
        report($sformatf("mem_write got %0b exp %0b", got.wr, exp.wr));
      if (got.addr !== exp.addr)
        report($sformatf("mem_addr got %0d exp %0d", got.addr, exp.addr));
      if (got.data !== exp.data)
        report($sformatf("mem_data got %h exp %h", got.data, exp.data));
      if (got.cur !== exp.cur)
        report($sformatf("cursor_address got %0d exp %0d", got.cur, exp.cur));
      if (got.view !== exp.view)
        report($sformatf("view_address got %0d exp %0d", got.view, exp.view));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  tcce_cfg_if cfg_ch ();
  tcce_cmd_if cmd_ch ();
  tcce_res_if res_ch ();

  console_scoreboard sb;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  bit eager;

  text_console_cursor_engine_core #(
    .LINE_WIDTH   (LINE_W),
    .SCREEN_CELLS (SCREEN_N)
  ) uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always #2 clk = ~clk;

  function automatic int gap_len();
    int x;
    x = $urandom_range(0, 99);
    if (x < 60) return 0;
    if (x < 90) return $urandom_range(1, 3);
    if (x < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // cmd valid is left high after a transfer; the next call lowers it only for a gap
  task send_cmd(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
    int gap;
    gap = eager ? 0 : gap_len();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.func      <= f;
    cmd_ch.char_code <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_cmd(f, c);
  endtask

  task wait_idle();
    cmd_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [END_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task send_random_item();
    int x;
    x = $urandom_range(0, 99);
    if (x < 62)      send_cmd(FUNC_PRINT, 8'($urandom_range(0, 255)));
    else if (x < 76) send_cmd(FUNC_PRINT, CH_NEWLINE);
    else if (x < 84) send_cmd(FUNC_PRINT, CH_BACKSPACE);
    else if (x < 90) send_cmd(FUNC_UP, 8'($urandom_range(0, 255)));
    else if (x < 96) send_cmd(FUNC_DOWN, 8'($urandom_range(0, 255)));
    else             send_cmd(FUNC_NONE, 8'($urandom_range(0, 255)));
  endtask

  task set_region(int p);
    int s, e, x;
    s = $urandom_range(0, 14000);
    x = $urandom_range(0, 9);
    if (x < 2)      s = 0;
    else if (x < 3) s = LAST_ADDR;
    x = $urandom_range(0, 9);
    if (p == 0 || x < 4) e = s + $urandom_range(60, 2600);
    else if (x < 6)      e = s + $urandom_range(2000, 4500);
    else if (x < 7)      e = TOP_WORDS;
    else if (x < 8)      e = 32767;
    else if (x < 9)      e = 0;
    else                 e = $urandom_range(0, 32767);
    // keeping the cursor while the end moves can leave it below a blocked view
    if (p == 0 || $urandom_range(0, 3) != 0) write_reg(REG_REGION_START, END_W'(s));
    write_reg(REG_REGION_END, END_W'(e));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_text_console_cursor_engine_core: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check({res_ch.mem_write, res_ch.mem_addr, res_ch.mem_data,
                res_ch.cursor_address, res_ch.view_address});
      results_seen <= results_seen + 1;
    end
  end

  initial begin
    bit calm, hold_done;
    int stall;
    calm = 1'b0;
    hold_done = 1'b0;
    stall = 0;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (!hold_done && results_seen >= 700) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if ($urandom_range(0, 299) == 0) calm = !calm;
        if (stall == 0 && !calm && $urandom_range(0, 3) == 0)
          stall = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        res_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
        @(posedge clk);
      end
    end
  end

  initial begin
    sb = new();
    eager = 1'b0;
    rst <= 1'b1;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_REGION_START;
    cfg_ch.data      <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.func      <= FUNC_PRINT;
    cmd_ch.char_code <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // tiny region: start and end guards, no room to scroll
    write_reg(REG_REGION_START, 15'd100);
    write_reg(REG_REGION_END, 15'd190);
    send_cmd(FUNC_PRINT, CH_BACKSPACE);
    send_cmd(FUNC_PRINT, 8'h00);
    send_cmd(FUNC_PRINT, 8'hff);
    send_cmd(FUNC_PRINT, CH_NEWLINE);
    send_cmd(FUNC_PRINT, CH_NEWLINE);
    for (int k = 0; k < 10; k++) send_cmd(FUNC_PRINT, 8'h41 + 8'(k));
    send_cmd(FUNC_UP, 8'h00);
    send_cmd(FUNC_DOWN, 8'hff);
    send_cmd(FUNC_NONE, 8'ha5);
    send_cmd(FUNC_PRINT, CH_BACKSPACE);
    wait_idle();

    // last word of memory, end beyond memory
    write_reg(REG_REGION_END, 15'h7fff);
    write_reg(REG_REGION_START, 15'h3fff);
    send_cmd(FUNC_PRINT, 8'h5a);
    send_cmd(FUNC_PRINT, CH_NEWLINE);
    send_cmd(FUNC_DOWN, 8'h00);
    send_cmd(FUNC_PRINT, CH_BACKSPACE);
    wait_idle();

    // empty region
    write_reg(REG_REGION_END, 15'd0);
    write_reg(REG_REGION_START, 15'd0);
    send_cmd(FUNC_PRINT, 8'h78);
    send_cmd(FUNC_UP, 8'h00);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      set_region(p);
      eager = (p % 3 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      wait_idle();
    end

    cmd_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_text_console_cursor_engine_core: PASS");
    end else begin
      $display("tb_text_console_cursor_engine_core: FAIL");
    end
    $finish;
  end

endmodule
